// ===== rtl/lrs_pkg.sv =====
// Shared codes, defaults and control types for the line rasterizer stepper.
// Used by lrs_setup, lrs_step and line_rasterizer_stepper_top; no dependencies.
package lrs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_OFFSET_X = 1'b0,
        CFG_OFFSET_Y = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        MINOR_HOLD = 2'b00,
        MINOR_INC  = 2'b01,
        MINOR_DEC  = 2'b11
    } minor_dir_t;

    typedef struct packed
    {
        logic       busy;
        logic       x_is_major;
        logic       major_dir;
        minor_dir_t minor_dir;
    } seg_ctl_t;

endpackage

// ===== rtl/lrs_setup.sv =====
// Segment setup: picks the major axis, spans and step directions from the
// offset endpoints. Combinational; depends on lrs_pkg.
module lrs_setup #(
    parameter int COORD_BITS = lrs_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS:0]   x1,
    input  logic [COORD_BITS:0]   y1,
    input  logic [COORD_BITS:0]   x2,
    input  logic [COORD_BITS:0]   y2,
    output logic [COORD_BITS:0]   major_pos,
    output logic [COORD_BITS:0]   minor_pos,
    output logic [COORD_BITS:0]   major_end,
    output logic [COORD_BITS+1:0] major_span,
    output logic [COORD_BITS+1:0] minor_span,
    output lrs_pkg::seg_ctl_t     ctl
);

    localparam int P = COORD_BITS + 1;
    localparam int S = COORD_BITS + 2;

    logic signed [S-1:0] ddx;
    logic signed [S-1:0] ddy;
    logic [S-1:0]        dx;
    logic [S-1:0]        dy;
    logic                x_major;
    logic signed [P-1:0] m0;
    logic signed [P-1:0] m1;
    logic signed [P-1:0] n0;
    logic signed [P-1:0] n1;

    assign ddx = $signed({x1[P-1], x1}) - $signed({x2[P-1], x2});
    assign ddy = $signed({y1[P-1], y1}) - $signed({y2[P-1], y2});
    assign dx  = ddx[S-1] ? S'(-ddx) : S'(ddx);
    assign dy  = ddy[S-1] ? S'(-ddy) : S'(ddy);

    assign x_major = dx > dy;

    assign m0 = x_major ? $signed(x1) : $signed(y1);
    assign m1 = x_major ? $signed(x2) : $signed(y2);
    assign n0 = x_major ? $signed(y1) : $signed(x1);
    assign n1 = x_major ? $signed(y2) : $signed(x2);

    assign major_pos  = m0;
    assign major_end  = m1;
    assign minor_pos  = n0;
    assign major_span = x_major ? dx : dy;
    assign minor_span = x_major ? dy : dx;

    always_comb
    begin
        ctl.busy       = x_major || (dy != '0);
        ctl.x_is_major = x_major;
        ctl.major_dir  = m1 < m0;
        if (n1 > n0)
        begin
            ctl.minor_dir = lrs_pkg::MINOR_INC;
        end
        else if (n1 < n0)
        begin
            ctl.minor_dir = lrs_pkg::MINOR_DEC;
        end
        else
        begin
            ctl.minor_dir = lrs_pkg::MINOR_HOLD;
        end
    end

endmodule

// ===== rtl/lrs_step.sv =====
// One Bresenham step: error update, minor and major advance, pixel in (x,y).
// Combinational; depends on lrs_pkg.
module lrs_step #(
    parameter int COORD_BITS = lrs_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS:0]   major_pos,
    input  logic [COORD_BITS:0]   minor_pos,
    input  logic [COORD_BITS:0]   major_end,
    input  logic [COORD_BITS+2:0] error_acc,
    input  logic [COORD_BITS+1:0] major_span,
    input  logic [COORD_BITS+1:0] minor_span,
    input  lrs_pkg::seg_ctl_t     ctl,
    output logic [COORD_BITS:0]   major_pos_next,
    output logic [COORD_BITS:0]   minor_pos_next,
    output logic [COORD_BITS+2:0] error_acc_next,
    output logic [COORD_BITS:0]   pixel_x,
    output logic [COORD_BITS:0]   pixel_y,
    output logic                  last
);

    localparam int P = COORD_BITS + 1;
    localparam int E = COORD_BITS + 3;

    logic [E-1:0] acc_sum;
    logic [E-1:0] wrap_at;
    logic         wrap;

    assign acc_sum = error_acc + E'(minor_span) + E'(1);
    assign wrap_at = E'(major_span) + E'(1);
    assign wrap    = acc_sum >= wrap_at;

    assign error_acc_next = wrap ? acc_sum - wrap_at : acc_sum;

    always_comb
    begin
        minor_pos_next = minor_pos;
        if (wrap)
        begin
            case (ctl.minor_dir)
                lrs_pkg::MINOR_INC: minor_pos_next = minor_pos + P'(1);
                lrs_pkg::MINOR_DEC: minor_pos_next = minor_pos - P'(1);
                default:            minor_pos_next = minor_pos;
            endcase
        end
    end

    assign major_pos_next = ctl.major_dir ? major_pos - P'(1) : major_pos + P'(1);
    assign last           = major_pos_next == major_end;

    assign pixel_x = ctl.x_is_major ? major_pos : minor_pos;
    assign pixel_y = ctl.x_is_major ? minor_pos : major_pos;

endmodule

// ===== rtl/line_rasterizer_stepper_top.sv =====
// Line rasterizer stepper top level: config offsets, input register, segment
// state and result register. Depends on lrs_pkg, lrs_setup and lrs_step.
//
// Takes one item per clock and returns one result per step command per clock,
// with pixel_valid low once the segment is done. The input register adds the
// pan offsets, then segment setup or one Bresenham step runs on the segment
// state and fills the result register. The step recurrence (error add,
// compare, subtract, position advance) feeds the segment state combinationally.
// A load produces no result and never waits on the output side; a step waits
// only while the result register holds an untaken pixel under out_stall.
module line_rasterizer_stepper_top #(
    parameter int COORD_BITS = lrs_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lrs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_BITS:0]           pixel_x,
    output logic signed [COORD_BITS:0]           pixel_y,
    output logic                                 pixel_valid,
    output logic                                 last_pixel
);

    localparam int C = COORD_BITS;
    localparam int P = COORD_BITS + 1;
    localparam int S = COORD_BITS + 2;
    localparam int E = COORD_BITS + 3;

    logic [C-1:0]      offset_x_reg;
    logic [C-1:0]      offset_y_reg;

    logic              s1_valid_reg;
    lrs_pkg::cmd_t     s1_cmd_reg;
    logic [P-1:0]      s1_x1_reg;
    logic [P-1:0]      s1_y1_reg;
    logic [P-1:0]      s1_x2_reg;
    logic [P-1:0]      s1_y2_reg;

    logic [P-1:0]      major_pos_reg;
    logic [P-1:0]      minor_pos_reg;
    logic [P-1:0]      major_end_reg;
    logic [E-1:0]      error_acc_reg;
    logic [S-1:0]      major_span_reg;
    logic [S-1:0]      minor_span_reg;
    lrs_pkg::seg_ctl_t ctl_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [P-1:0]      pixel_x_reg;
    logic [P-1:0]      pixel_y_reg;
    logic              pixel_valid_reg;
    logic              last_pixel_reg;

    logic              in_xfer;
    logic              s1_is_step;
    logic              s1_advance;
    logic              s1_valid_next;

    logic [P-1:0]      su_major_pos;
    logic [P-1:0]      su_minor_pos;
    logic [P-1:0]      su_major_end;
    logic [S-1:0]      su_major_span;
    logic [S-1:0]      su_minor_span;
    lrs_pkg::seg_ctl_t su_ctl;

    logic [P-1:0]      st_major_pos;
    logic [P-1:0]      st_minor_pos;
    logic [E-1:0]      st_error_acc;
    logic [P-1:0]      st_pixel_x;
    logic [P-1:0]      st_pixel_y;
    logic              st_last;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (lrs_pkg::cfg_index_t'(cfg_index))
                lrs_pkg::CFG_OFFSET_X: offset_x_reg <= cfg_wdata;
                lrs_pkg::CFG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                default:               offset_x_reg <= offset_x_reg;
            endcase
        end
    end

    // Handshake
    assign s1_is_step    = s1_cmd_reg == lrs_pkg::CMD_STEP;
    assign s1_advance    = s1_valid_reg && (!s1_is_step || !out_valid_reg || !out_stall);
    assign in_stall      = s1_valid_reg && !s1_advance;
    assign in_xfer       = in_valid && !in_stall;
    assign s1_valid_next = in_xfer || (s1_valid_reg && !s1_advance);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (s1_advance && s1_is_step)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Input register: add pan offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg <= lrs_pkg::cmd_t'(command);
            s1_x1_reg  <= {start_x[C-1], start_x} + {offset_x_reg[C-1], offset_x_reg};
            s1_y1_reg  <= {start_y[C-1], start_y} + {offset_y_reg[C-1], offset_y_reg};
            s1_x2_reg  <= {end_x[C-1], end_x} + {offset_x_reg[C-1], offset_x_reg};
            s1_y2_reg  <= {end_y[C-1], end_y} + {offset_y_reg[C-1], offset_y_reg};
        end
    end

    lrs_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x1         (s1_x1_reg),
        .y1         (s1_y1_reg),
        .x2         (s1_x2_reg),
        .y2         (s1_y2_reg),
        .major_pos  (su_major_pos),
        .minor_pos  (su_minor_pos),
        .major_end  (su_major_end),
        .major_span (su_major_span),
        .minor_span (su_minor_span),
        .ctl        (su_ctl)
    );

    lrs_step #(
        .COORD_BITS     (COORD_BITS)
    ) u_step (
        .major_pos      (major_pos_reg),
        .minor_pos      (minor_pos_reg),
        .major_end      (major_end_reg),
        .error_acc      (error_acc_reg),
        .major_span     (major_span_reg),
        .minor_span     (minor_span_reg),
        .ctl            (ctl_reg),
        .major_pos_next (st_major_pos),
        .minor_pos_next (st_minor_pos),
        .error_acc_next (st_error_acc),
        .pixel_x        (st_pixel_x),
        .pixel_y        (st_pixel_y),
        .last           (st_last)
    );

    // Segment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            major_end_reg  <= '0;
            error_acc_reg  <= '0;
            major_span_reg <= '0;
            minor_span_reg <= '0;
            ctl_reg        <= '0;
        end
        else if (s1_advance)
        begin
            if (!s1_is_step)
            begin
                major_pos_reg  <= su_major_pos;
                minor_pos_reg  <= su_minor_pos;
                major_end_reg  <= su_major_end;
                error_acc_reg  <= '0;
                major_span_reg <= su_major_span;
                minor_span_reg <= su_minor_span;
                ctl_reg        <= su_ctl;
            end
            else if (ctl_reg.busy)
            begin
                major_pos_reg <= st_major_pos;
                minor_pos_reg <= st_minor_pos;
                error_acc_reg <= st_error_acc;
                ctl_reg.busy  <= !st_last;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_is_step)
        begin
            pixel_valid_reg <= ctl_reg.busy;
            pixel_x_reg     <= ctl_reg.busy ? st_pixel_x : '0;
            pixel_y_reg     <= ctl_reg.busy ? st_pixel_y : '0;
            last_pixel_reg  <= ctl_reg.busy && st_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_valid = pixel_valid_reg;
    assign last_pixel  = last_pixel_reg;

`ifndef SYNTHESIS
    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_pixel_reg |-> pixel_valid_reg)
        else $error("last pixel flagged without a pixel");

    a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_is_step && ctl_reg.busy && st_last |=> !ctl_reg.busy)
        else $error("segment still active after its last pixel");

    a_error_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.busy |-> error_acc_reg <= E'(major_span_reg))
        else $error("error term beyond major span");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_is_step && out_valid_reg)
        else $error("input stalled with no step waiting on the result register");
`endif

endmodule
